// ===== src/integer_alu_mul_div_unit_top_assert.svh =====
// Assertion macros for the integer execute unit
`ifndef INTEGER_ALU_MUL_DIV_UNIT_TOP_ASSERT_SVH
`define INTEGER_ALU_MUL_DIV_UNIT_TOP_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle
`define IAMD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define IAMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/iamd_pkg.sv =====
// Shared types and constants of the integer execute unit
`default_nettype none
package iamd_pkg;
    localparam int DataW   = 32;
    localparam int QDepth  = 2;
    localparam int DivSteps = 32;

    typedef enum logic [3:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MULS   = 4'd2,
        MODE_MULU   = 4'd3,
        MODE_DIVS   = 4'd4,
        MODE_DIVU   = 4'd5,
        MODE_CLZ    = 4'd6,
        MODE_CLO    = 4'd7,
        MODE_GETB   = 4'd8,
        MODE_SETB   = 4'd9,
        MODE_SEXT16 = 4'd10,
        MODE_ZEXT16 = 4'd11
    } mode_t;

    // Operation classes decided by the front end
    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2
    } cls_t;

    // Classified request carried from the front end to the back end
    typedef struct packed {
        cls_t             cls;
        logic [DataW-1:0] a;      // magnitude for divide, raw for multiply
        logic [DataW-1:0] b;
        logic             neg_q;  // negate quotient
        logic             neg_r;  // negate remainder
        logic             sgn;    // signed multiply
        logic             zero;   // divide by zero
        logic [DataW-1:0] lo;     // precomputed result of simple modes
        logic             ovf;
    } req_t;
endpackage
`default_nettype wire

// ===== src/iamd_front.sv =====
// Front end: accept a request, compute simple modes, prepare mul/div operands
`default_nettype none
module iamd_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [3:0]                mode,
    input  wire logic [iamd_pkg::DataW-1:0] operand_a,
    input  wire logic [iamd_pkg::DataW-1:0] operand_b,
    input  wire logic [1:0]                byte_index,
    input  wire logic [7:0]                byte_value,
    output iamd_pkg::req_t                 q_data,
    output logic                           q_valid,
    input  wire logic                      q_ready
);
    import iamd_pkg::*;

    req_t   slot_reg [QDepth];
    logic   wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    req_t   req;
    logic [DataW-1:0] sum, diff;
    logic [5:0] lz_a, lz_na;
    logic [4:0] sh;
    logic   push, pop;

    // Count leading zeros through a priority scan
    function automatic logic [5:0] lead_zeros(input logic [DataW-1:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < DataW; i++)
        begin
            if (v[i])
            begin
                n = 6'(DataW - 1 - i);
            end
        end
        return n;
    endfunction

    assign sum   = operand_a + operand_b;
    assign diff  = operand_a - operand_b;
    assign lz_a  = lead_zeros(operand_a);
    assign lz_na = lead_zeros(~operand_a);
    assign sh    = {byte_index, 3'b000};

    // Classify the request
    always_comb
    begin
        req       = '0;
        req.cls   = CLS_SIMPLE;
        req.a     = operand_a;
        req.b     = operand_b;
        case (mode)
            MODE_ADD:
            begin
                req.lo  = sum;
                req.ovf = ~(operand_a[31] ^ operand_b[31]) & (operand_a[31] ^ sum[31]);
            end
            MODE_SUB:
            begin
                req.lo  = diff;
                req.ovf = (operand_a[31] ^ operand_b[31]) & (operand_a[31] ^ diff[31]);
            end
            MODE_MULS, MODE_MULU:
            begin
                req.cls = CLS_MUL;
                req.sgn = (mode == MODE_MULS);
            end
            MODE_DIVS:
            begin
                req.cls   = CLS_DIV;
                req.a     = operand_a[31] ? -operand_a : operand_a;
                req.b     = operand_b[31] ? -operand_b : operand_b;
                req.neg_q = operand_a[31] ^ operand_b[31];
                req.neg_r = operand_a[31];
                req.zero  = (operand_b == '0);
            end
            MODE_DIVU:
            begin
                req.cls  = CLS_DIV;
                req.zero = (operand_b == '0);
            end
            MODE_CLZ:    req.lo = {26'd0, lz_a};
            MODE_CLO:    req.lo = {26'd0, lz_na};
            MODE_GETB:   req.lo = {24'd0, 8'(operand_a >> sh)};
            MODE_SETB:   req.lo = (operand_a & ~(32'hff << sh)) | ({24'd0, byte_value} << sh);
            MODE_SEXT16: req.lo = {{16{operand_a[15]}}, operand_a[15:0]};
            MODE_ZEXT16: req.lo = {16'd0, operand_a[15:0]};
            default:     req.lo = '0;
        endcase
    end

    assign in_ready = (cnt_reg != 2'(QDepth));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = slot_reg[rd_ptr_reg];

    // Write queue slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= req;
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== src/iamd_back.sv =====
// Back end: pipelined multiplier and divider with aligned result delivery
`default_nettype none
module iamd_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire iamd_pkg::req_t             q_data,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [iamd_pkg::DataW-1:0]      result_low,
    output logic [iamd_pkg::DataW-1:0]      result_high,
    output logic                            overflow
);
    import iamd_pkg::*;

    localparam int Depth = DivSteps + 3;

    // One pipeline slot
    typedef struct packed {
        logic             v;
        cls_t             cls;
        logic             neg_q, neg_r, zero, ovf;
        logic [DataW-1:0] lo;      // simple result or quotient being built
        logic [DataW-1:0] rem;     // partial remainder
        logic [DataW-1:0] a;       // dividend bits still to shift
        logic [DataW-1:0] b;       // divisor
        logic [DataW-1:0] pl, pm1, pm2, ph; // multiplier partial products
        logic             sgn;
        logic [DataW-1:0] sa, sb;  // raw operands for sign correction
    } stage_t;

    stage_t st_reg [Depth];
    stage_t st_next [Depth];
    logic   adv;
    logic [DataW:0] trial;
    logic [2*DataW-1:0] prod;

    // Whole pipe advances unless the tail is held by the consumer
    assign adv      = !(st_reg[Depth-1].v && !out_ready);
    assign q_ready  = adv;
    assign out_valid = st_reg[Depth-1].v;

    always_comb
    begin
        // Stage 0: load and split multiply into 16x16 partial products
        st_next[0]       = '0;
        st_next[0].v     = q_valid;
        st_next[0].cls   = q_data.cls;
        st_next[0].neg_q = q_data.neg_q;
        st_next[0].neg_r = q_data.neg_r;
        st_next[0].zero  = q_data.zero;
        st_next[0].ovf   = q_data.ovf;
        st_next[0].lo    = (q_data.cls == CLS_SIMPLE) ? q_data.lo : '0;
        st_next[0].a     = q_data.a;
        st_next[0].b     = q_data.b;
        st_next[0].sgn   = q_data.sgn;
        st_next[0].sa    = q_data.a;
        st_next[0].sb    = q_data.b;
        st_next[0].pl    = q_data.a[15:0]  * q_data.b[15:0];
        st_next[0].pm1   = q_data.a[31:16] * q_data.b[15:0];
        st_next[0].pm2   = q_data.a[15:0]  * q_data.b[31:16];
        st_next[0].ph    = q_data.a[31:16] * q_data.b[31:16];
        trial = '0;
        prod  = '0;
        // Divide stages: one restoring step per stage
        for (int s = 1; s <= DivSteps; s++)
        begin
            st_next[s] = st_reg[s-1];
            if (st_reg[s-1].cls == CLS_DIV)
            begin
                trial = {st_reg[s-1].rem, st_reg[s-1].a[DataW-1]} - {1'b0, st_reg[s-1].b};
                st_next[s].a = {st_reg[s-1].a[DataW-2:0], 1'b0};
                if (!trial[DataW])
                begin
                    st_next[s].rem = trial[DataW-1:0];
                    st_next[s].lo  = {st_reg[s-1].lo[DataW-2:0], 1'b1};
                end
                else
                begin
                    st_next[s].rem = {st_reg[s-1].rem[DataW-2:0], st_reg[s-1].a[DataW-1]};
                    st_next[s].lo  = {st_reg[s-1].lo[DataW-2:0], 1'b0};
                end
            end
        end
        // Sum partial products into the unsigned product
        st_next[DivSteps+1] = st_reg[DivSteps];
        prod = {st_reg[DivSteps].ph, st_reg[DivSteps].pl}
             + {16'd0, st_reg[DivSteps].pm1, 16'd0}
             + {16'd0, st_reg[DivSteps].pm2, 16'd0};
        if (st_reg[DivSteps].cls == CLS_MUL)
        begin
            st_next[DivSteps+1].lo  = prod[DataW-1:0];
            st_next[DivSteps+1].rem = prod[2*DataW-1:DataW];
        end
        // Final stage: sign corrections, zeroing for divide by zero
        st_next[DivSteps+2] = st_reg[DivSteps+1];
        case (st_reg[DivSteps+1].cls)
            CLS_MUL:
            begin
                if (st_reg[DivSteps+1].sgn)
                begin
                    st_next[DivSteps+2].rem = st_reg[DivSteps+1].rem
                        - (st_reg[DivSteps+1].sa[31] ? st_reg[DivSteps+1].sb : '0)
                        - (st_reg[DivSteps+1].sb[31] ? st_reg[DivSteps+1].sa : '0);
                end
            end
            CLS_DIV:
            begin
                if (st_reg[DivSteps+1].zero)
                begin
                    st_next[DivSteps+2].lo  = '0;
                    st_next[DivSteps+2].rem = '0;
                end
                else
                begin
                    st_next[DivSteps+2].lo = st_reg[DivSteps+1].neg_q
                        ? -st_reg[DivSteps+1].lo : st_reg[DivSteps+1].lo;
                    st_next[DivSteps+2].rem = st_reg[DivSteps+1].neg_r
                        ? -st_reg[DivSteps+1].rem : st_reg[DivSteps+1].rem;
                end
            end
            default:
            begin
                st_next[DivSteps+2].rem = '0;
            end
        endcase
    end

    // Advance the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Depth; s++)
            begin
                st_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            for (int s = 0; s < Depth; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign result_low  = st_reg[Depth-1].lo;
    assign result_high = st_reg[Depth-1].rem;
    assign overflow    = st_reg[Depth-1].ovf;
endmodule
`default_nettype wire

// ===== src/integer_alu_mul_div_unit_top.sv =====
// Top level of the integer execute unit
`default_nettype none
// Accepts one request per cycle and returns one result per request in order.
// Every request passes through a 35-stage pipeline (one load stage with
// 16x16 partial products, 32 restoring-divide stages of one quotient bit
// each, a product-sum stage and a sign-correction stage) behind a two-entry
// front queue, which a request passes before the load stage. Without stalls
// throughput is one request per cycle. A stalled consumer holds the whole
// pipeline; the front queue then fills and input stalls too.
`include "integer_alu_mul_div_unit_top_assert.svh"
module integer_alu_mul_div_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  mode,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    input  wire logic [1:0]  byte_index,
    input  wire logic [7:0]  byte_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result_low,
    output logic [31:0]      result_high,
    output logic             overflow
);
    import iamd_pkg::*;

    req_t q_data;
    logic q_valid, q_ready;

    iamd_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .mode, .operand_a, .operand_b,
        .byte_index, .byte_value, .q_data, .q_valid, .q_ready
    );

    iamd_back u_back (
        .clk, .rst_n, .q_data, .q_valid, .q_ready, .out_valid, .out_ready,
        .result_low, .result_high, .overflow
    );

    `IAMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_low))
    `IAMD_ASSERT_IMP(a_q_stall, out_valid && !out_ready, !q_ready)
    `IAMD_ASSERT_IMP(a_ovf_only_addsub, out_valid && overflow, result_high == 32'd0)
endmodule
`default_nettype wire

// ===== dv/integer_alu_mul_div_unit_top_tb.sv =====
// Testbench of the integer execute unit: random and directed requests checked in order
`timescale 1ns / 100ps
`default_nettype none
module integer_alu_mul_div_unit_top_tb;
    import iamd_pkg::*;

    // Predicted result of one request
    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        ovf;
    } alu_result_t;

    // Compute the expected result of one request
    function automatic alu_result_t compute_result(logic [3:0] op, logic [31:0] a,
                                                    logic [31:0] b, logic [1:0] idx,
                                                    logic [7:0] bv);
        alu_result_t r;
        logic [63:0] prod;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] w;
        int          n;
        r.lo = '0;
        r.hi = '0;
        r.ovf = 1'b0;
        case (op) inside
            MODE_ADD:
            begin
                r.lo = a + b;
                r.ovf = ~(a[31] ^ b[31]) & (a[31] ^ r.lo[31]);
            end
            MODE_SUB:
            begin
                r.lo = a - b;
                r.ovf = (a[31] ^ b[31]) & (a[31] ^ r.lo[31]);
            end
            MODE_MULS:
            begin
                prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                {r.hi, r.lo} = prod;
            end
            MODE_MULU:
            begin
                prod = {32'd0, a} * {32'd0, b};
                {r.hi, r.lo} = prod;
            end
            MODE_DIVS:
            begin
                if (b != 0)
                begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    rem = ma % mb;
                    r.lo = (a[31] != b[31]) ? -q : q;
                    r.hi = a[31] ? -rem : rem;
                end
            end
            MODE_DIVU:
            begin
                if (b != 0)
                begin
                    r.lo = a / b;
                    r.hi = a % b;
                end
            end
            MODE_CLZ, MODE_CLO:
            begin
                w = (op == MODE_CLO) ? ~a : a;
                n = 0;
                while (n < 32 && !w[31 - n])
                    n++;
                r.lo = n;
            end
            MODE_GETB:
                r.lo = (a >> (idx * 8)) & 32'hff;
            MODE_SETB:
                r.lo = (a & ~(32'hff << (idx * 8))) | ({24'd0, bv} << (idx * 8));
            MODE_SEXT16:
                r.lo = {{16{a[15]}}, a[15:0]};
            MODE_ZEXT16:
                r.lo = {16'd0, a[15:0]};
            default:
                r.lo = '0;
        endcase
        return r;
    endfunction

    // Hold pending expectations and compare arriving results
    class result_scoreboard;
        alu_result_t pending[$];
        int          errors;
        int          checked;

        function void note_request(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                   logic [1:0] idx, logic [7:0] bv);
            pending.push_back(compute_result(op, a, b, idx, bv));
        endfunction

        function void check_result(logic [31:0] lo, logic [31:0] hi, logic ovf);
            alu_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing pending lo=%h hi=%h ovf=%b",
                         $time, lo, hi, ovf);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (lo !== e.lo)
            begin
                $display("%0t: result_low expected %h actual %h", $time, e.lo, lo);
                errors++;
            end
            if (hi !== e.hi)
            begin
                $display("%0t: result_high expected %h actual %h", $time, e.hi, hi);
                errors++;
            end
            if (ovf !== e.ovf)
            begin
                $display("%0t: overflow expected %b actual %b", $time, e.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  mode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [1:0]  byte_index;
    logic [7:0]  byte_value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        overflow;

    result_scoreboard sb;
    int               idle_cycles = 0;
    int               sent;
    bit               hold_off;
    bit               hold_done;

    integer_alu_mul_div_unit_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .byte_index (byte_index),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_low (result_low),
        .result_high(result_high),
        .overflow   (overflow)
    );

    // Generate the clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Note accepted requests and check results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(mode, operand_a, operand_b, byte_index, byte_value);
            if (out_valid && out_ready)
                sb.check_result(result_low, result_high, overflow);
        end
    end

    // Count cycles with no handshake; end the run when stuck
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("timeout with %0d results pending", sb.pending.size());
            $display("FAIL");
            $finish;
        end
    end

    // Pick an operand that favors edge values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return 32'h80000000;
            3: return 32'h7fffffff;
            4: return $urandom_range(0, 16);
            5: return -$urandom_range(1, 16);
            6: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Offer one request and wait until it is accepted
    task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                logic [1:0] idx, logic [7:0] bv);
        in_valid   <= 1'b1;
        mode       <= op;
        operand_a  <= a;
        operand_b  <= b;
        byte_index <= idx;
        byte_value <= bv;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    // Drop valid for a random gap
    task automatic idle_gap(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Stall the receiver on its own pattern, with one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 1) != 0);
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
            if ($urandom_range(0, 20) == 0)
                repeat ($urandom_range(5, 40)) @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        logic [3:0] op;
        int         burst;
        sb = new();
        sent = 0;
        hold_off = 1'b0;
        hold_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = '0;
        operand_a = '0;
        operand_b = '0;
        byte_index = '0;
        byte_value = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: edges, every mode, divide by zero, minimum by minus one
        send_request(MODE_ADD, 32'h7fffffff, 32'h1, 2'd0, 8'h00);
        send_request(MODE_ADD, 32'h80000000, 32'h80000000, 2'd3, 8'hff);
        send_request(MODE_SUB, 32'h80000000, 32'h1, 2'd0, 8'h00);
        send_request(MODE_SUB, 32'h0, 32'hffffffff, 2'd0, 8'h00);
        send_request(MODE_MULS, 32'h80000000, 32'h80000000, 2'd0, 8'h00);
        send_request(MODE_MULS, 32'hffffffff, 32'h7fffffff, 2'd0, 8'h00);
        send_request(MODE_MULU, 32'hffffffff, 32'hffffffff, 2'd0, 8'h00);
        send_request(MODE_DIVS, 32'h80000000, 32'hffffffff, 2'd0, 8'h00);
        send_request(MODE_DIVS, 32'h12345678, 32'h0, 2'd0, 8'h00);
        send_request(MODE_DIVS, 32'hfffffff9, 32'h2, 2'd0, 8'h00);
        send_request(MODE_DIVU, 32'hffffffff, 32'h0, 2'd0, 8'h00);
        send_request(MODE_DIVU, 32'hffffffff, 32'h7, 2'd0, 8'h00);
        send_request(MODE_CLZ, 32'h0, 32'h0, 2'd0, 8'h00);
        send_request(MODE_CLZ, 32'h80000000, 32'h0, 2'd0, 8'h00);
        send_request(MODE_CLO, 32'hffffffff, 32'h0, 2'd0, 8'h00);
        send_request(MODE_CLO, 32'h0, 32'h0, 2'd0, 8'h00);
        send_request(MODE_GETB, 32'hdeadbeef, 32'h0, 2'd3, 8'h00);
        send_request(MODE_SETB, 32'hffffffff, 32'h0, 2'd2, 8'h00);
        send_request(MODE_SETB, 32'h0, 32'h0, 2'd1, 8'hff);
        send_request(MODE_SEXT16, 32'h00008000, 32'h0, 2'd0, 8'h00);
        send_request(MODE_ZEXT16, 32'hffffffff, 32'h0, 2'd0, 8'h00);
        send_request(4'd12, 32'hffffffff, 32'hffffffff, 2'd3, 8'hff);
        send_request(4'd15, 32'h1, 32'h1, 2'd0, 8'h00);

        // Random bursts; one long receiver hold-off early on
        while (sent < 1650)
        begin
            if (sent > 200 && !hold_done)
            begin
                hold_off = 1'b1;
                hold_done = 1'b1;
            end
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                  : 4'($urandom_range(0, 11));
                send_request(op, pick_operand(), pick_operand(),
                             2'($urandom_range(0, 3)), 8'($urandom));
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 8));
        end
        in_valid <= 1'b0;

        // Drain and settle
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("%0d requests over all modes with edge operands and stalls, %0d results checked",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/iamd_pkg.sv
src/iamd_front.sv
src/iamd_back.sv
src/integer_alu_mul_div_unit_top.sv
dv/integer_alu_mul_div_unit_top_tb.sv
